// ===== rtl/fam_pkg.sv =====
// Shared types, constants and helpers for the fully associative LRU cache model.
// Used by every module of the block except fam_ram; depends on nothing.
`default_nettype none

package fam_pkg;

  localparam int WAYS_DEFAULT = 8;
  localparam int ADDR_W       = 32;
  localparam int CNT_W        = 32;
  localparam int DEPTH_OUT_W  = 6;
  localparam int OCC_W        = 7;
  localparam int OFFSET_W     = 4;
  localparam int SET_W        = 5;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int SHIFT_W      = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SET_INDEX   = 2'd1;

  localparam logic [OFFSET_W-1:0] LINE_OFFSET_RESET = 4'd6;
  localparam logic [SET_W-1:0]    SET_INDEX_RESET   = 5'd0;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_HIST
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] tag;
    logic              is_write;
  } item_t;

  typedef struct packed {
    logic pop;
    logic load;
    logic hist_we;
  } back_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module fam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/fam_queue.sv =====
// Two-entry transaction queue between the front and back parts.
// Depends on fam_pkg for the item type.
`default_nettype none

module fam_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire fam_pkg::item_t push_item,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output fam_pkg::item_t     pop_item
);

  fam_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fam_front.sv =====
// Front part: configuration registers, input acceptance and tag formation.
// Depends on fam_pkg.
`default_nettype none

module fam_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [fam_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fam_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              operation,
  input  wire logic [fam_pkg::ADDR_W-1:0]        address,
  input  wire logic                              is_write,
  output logic                                   push_valid,
  input  wire logic                              push_ready,
  output fam_pkg::item_t                         push_item
);

  logic [fam_pkg::OFFSET_W-1:0] line_offset_bits;
  logic [fam_pkg::SET_W-1:0]    set_index_bits;
  logic [fam_pkg::SHIFT_W-1:0]  shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset_bits <= fam_pkg::LINE_OFFSET_RESET;
      set_index_bits   <= fam_pkg::SET_INDEX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fam_pkg::REG_LINE_OFFSET: line_offset_bits <= cfg_data[fam_pkg::OFFSET_W-1:0];
        fam_pkg::REG_SET_INDEX:   set_index_bits   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign shift = fam_pkg::SHIFT_W'(line_offset_bits) + fam_pkg::SHIFT_W'(set_index_bits);

  always_comb begin
    push_item.op       = fam_pkg::op_t'(operation);
    push_item.is_write = is_write;
    if (shift >= fam_pkg::SHIFT_W'(fam_pkg::ADDR_W)) begin
      push_item.tag = '0;
    end else begin
      push_item.tag = address >> shift[4:0];
    end
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

`default_nettype wire

// ===== rtl/fam_back.sv =====
// Back part: LRU tag stack, hit search, statistics and the result register.
// Depends on fam_pkg and fam_ram (depth histogram).
`default_nettype none

module fam_back #(
  parameter int WAYS = fam_pkg::WAYS_DEFAULT,
  localparam int NW = $clog2(WAYS + 1),
  localparam int DW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pop_valid,
  output logic                                   pop_ready,
  input  wire fam_pkg::item_t                    pop_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   hit,
  output logic [fam_pkg::DEPTH_OUT_W-1:0]        hit_depth,
  output logic [fam_pkg::CNT_W-1:0]              depth_count,
  output logic [fam_pkg::CNT_W-1:0]              read_hit_count,
  output logic [fam_pkg::CNT_W-1:0]              read_miss_count,
  output logic [fam_pkg::CNT_W-1:0]              write_hit_count,
  output logic [fam_pkg::CNT_W-1:0]              write_miss_count,
  output logic [fam_pkg::OCC_W-1:0]              occupancy
);

  fam_pkg::back_state_t state;
  fam_pkg::back_state_t state_next;
  fam_pkg::back_ctrl_t  ctrl;

  logic [fam_pkg::ADDR_W-1:0] tags [WAYS];
  logic [NW-1:0]              entry_count;
  logic [fam_pkg::CNT_W-1:0]  rd_hit_cnt;
  logic [fam_pkg::CNT_W-1:0]  rd_miss_cnt;
  logic [fam_pkg::CNT_W-1:0]  wr_hit_cnt;
  logic [fam_pkg::CNT_W-1:0]  wr_miss_cnt;
  logic [WAYS-1:0]            hist_valid;
  logic                       hit_q;
  logic [DW-1:0]              depth_q;

  logic [WAYS-1:0]            match;
  logic                       found;
  logic [DW-1:0]              found_depth;
  logic                       access;
  logic                       is_hit;
  logic [NW-1:0]              limit;
  logic [WAYS-1:0]            shift_en;
  logic [fam_pkg::CNT_W-1:0]  ram_rdata;
  logic [fam_pkg::CNT_W-1:0]  hist_cur;
  logic [fam_pkg::CNT_W-1:0]  hist_new;

  always_comb begin
    found       = 1'b0;
    found_depth = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (NW'(i) < entry_count) && (tags[i] == pop_item.tag);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found       = 1'b1;
        found_depth = DW'(i);
      end
    end
  end

  assign access = (pop_item.op == fam_pkg::OP_ACCESS);
  assign is_hit = access && found;

  always_comb begin
    if (is_hit) begin
      limit = NW'(found_depth);
    end else if (entry_count == NW'(WAYS)) begin
      limit = NW'(WAYS - 1);
    end else begin
      limit = entry_count;
    end
    for (int i = 0; i < WAYS; i++) begin
      shift_en[i] = (NW'(i) <= limit);
    end
  end

  always_comb begin
    case (state)
      fam_pkg::BK_IDLE: state_next = ctrl.pop ? fam_pkg::BK_HIST : fam_pkg::BK_IDLE;
      fam_pkg::BK_HIST: state_next = fam_pkg::BK_IDLE;
      default:          state_next = fam_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      fam_pkg::BK_IDLE: ctrl.pop = pop_valid && (!out_valid || out_ready);
      fam_pkg::BK_HIST: begin
        ctrl.load    = 1'b1;
        ctrl.hist_we = hit_q;
      end
      default: ctrl = '0;
    endcase
  end

  assign pop_ready = ctrl.pop;

  assign hist_cur = hist_valid[depth_q] ? ram_rdata : '0;
  assign hist_new = fam_pkg::sat_inc(hist_cur);

  fam_ram #(
    .WIDTH (fam_pkg::CNT_W),
    .DEPTH (WAYS)
  ) u_hist (
    .clk   (clk),
    .we    (ctrl.hist_we),
    .waddr (depth_q),
    .wdata (hist_new),
    .raddr (found_depth),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fam_pkg::BK_IDLE;
      entry_count <= '0;
      rd_hit_cnt  <= '0;
      rd_miss_cnt <= '0;
      wr_hit_cnt  <= '0;
      wr_miss_cnt <= '0;
      hist_valid  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.pop) begin
        if (!access) begin
          entry_count <= '0;
        end else if (is_hit) begin
          if (pop_item.is_write) begin
            wr_hit_cnt <= fam_pkg::sat_inc(wr_hit_cnt);
          end else begin
            rd_hit_cnt <= fam_pkg::sat_inc(rd_hit_cnt);
          end
        end else begin
          if (pop_item.is_write) begin
            wr_miss_cnt <= fam_pkg::sat_inc(wr_miss_cnt);
          end else begin
            rd_miss_cnt <= fam_pkg::sat_inc(rd_miss_cnt);
          end
          entry_count <= limit + NW'(1);
        end
      end
      if (ctrl.hist_we) begin
        hist_valid[depth_q] <= 1'b1;
      end
      if (ctrl.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      hit_q   <= is_hit;
      depth_q <= is_hit ? found_depth : '0;
    end
    if (ctrl.load) begin
      hit         <= hit_q;
      hit_depth   <= fam_pkg::DEPTH_OUT_W'(depth_q);
      depth_count <= hit_q ? hist_new : '0;
    end
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_stack
    always_ff @(posedge clk) begin
      if (ctrl.pop && access) begin
        if (g == 0) begin
          tags[g] <= pop_item.tag;
        end else if (shift_en[g]) begin
          tags[g] <= tags[(g > 0) ? g - 1 : 0];
        end
      end
    end
  end

  assign read_hit_count   = rd_hit_cnt;
  assign read_miss_count  = rd_miss_cnt;
  assign write_hit_count  = wr_hit_cnt;
  assign write_miss_count = wr_miss_cnt;
  assign occupancy        = fam_pkg::OCC_W'(entry_count);

endmodule

`default_nettype wire

// ===== rtl/fully_assoc_lru_cache_model_core.sv =====
// Top level of the fully associative LRU cache model.
// Depends on fam_pkg, fam_front, fam_queue and fam_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries operation, address and is_write;
//   operation selects an access or a flush of all entries. Output channel
//   (out_valid/out_ready) returns one result per transaction: hit, hit_depth,
//   depth_count, the four saturating hit/miss counters and occupancy.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 = line offset bits, 1 = set index bits); other indexes are ignored.
//   An accepted transaction passes the queue, is popped by the back part and
//   then loads the result register; the back part takes no new transaction
//   until the depth histogram RAM read is followed by its write-back.
//   A two-entry queue sits between front and back, so up to two further
//   transactions are taken while a result waits on out_ready; beyond that
//   in_ready drops until the receiver takes the result.
//   Reset clears occupancy, counters and histogram valid bits directly,
//   with no clearing pass; statistics survive a flush.
`default_nettype none

module fully_assoc_lru_cache_model_core #(
  parameter int WAYS = fam_pkg::WAYS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [fam_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fam_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              operation,
  input  wire logic [fam_pkg::ADDR_W-1:0]        address,
  input  wire logic                              is_write,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   hit,
  output logic [fam_pkg::DEPTH_OUT_W-1:0]        hit_depth,
  output logic [fam_pkg::CNT_W-1:0]              depth_count,
  output logic [fam_pkg::CNT_W-1:0]              read_hit_count,
  output logic [fam_pkg::CNT_W-1:0]              read_miss_count,
  output logic [fam_pkg::CNT_W-1:0]              write_hit_count,
  output logic [fam_pkg::CNT_W-1:0]              write_miss_count,
  output logic [fam_pkg::OCC_W-1:0]              occupancy
);

  logic           push_valid;
  logic           push_ready;
  fam_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  fam_pkg::item_t pop_item;

  fam_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .address    (address),
    .is_write   (is_write),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  fam_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  fam_back #(
    .WAYS (WAYS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .hit              (hit),
    .hit_depth        (hit_depth),
    .depth_count      (depth_count),
    .read_hit_count   (read_hit_count),
    .read_miss_count  (read_miss_count),
    .write_hit_count  (write_hit_count),
    .write_miss_count (write_miss_count),
    .occupancy        (occupancy)
  );

endmodule

`default_nettype wire

// ===== rtl/fam_checker.sv =====
// Port-level checks on the cache model's result channel, bound to the top level.
// Depends on fam_pkg and fully_assoc_lru_cache_model_core.
`default_nettype none

module fam_checker #(
  parameter int WAYS = fam_pkg::WAYS_DEFAULT
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              hit,
  input wire logic [fam_pkg::DEPTH_OUT_W-1:0]   hit_depth,
  input wire logic [fam_pkg::CNT_W-1:0]         depth_count,
  input wire logic [fam_pkg::OCC_W-1:0]         occupancy
);

  // hold a stalled result: out_valid, hit and depth_count stay
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(depth_count))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_depth == '0 && depth_count == '0)
    else $error("miss result carries depth data");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> depth_count != '0 && occupancy != '0 &&
      fam_pkg::OCC_W'(hit_depth) < occupancy)
    else $error("hit result inconsistent with occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= fam_pkg::OCC_W'(WAYS))
    else $error("occupancy beyond way count");

endmodule

bind fully_assoc_lru_cache_model_core fam_checker #(.WAYS(WAYS)) u_fam_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .hit_depth   (hit_depth),
  .depth_count (depth_count),
  .occupancy   (occupancy)
);

`default_nettype wire
